### rtl/lcdseq_pkg.sv
// Shared types, codes and constant tables for the character LCD nibble sequencer.
// No dependencies; used by the front, queue, back and top-level modules.
package lcdseq_pkg;

  // request codes on in_action
  localparam logic [3:0] ACT_CHAR      = 4'd0;
  localparam logic [3:0] ACT_COMMAND   = 4'd1;
  localparam logic [3:0] ACT_CLEAR     = 4'd2;
  localparam logic [3:0] ACT_CURSOR    = 4'd3;
  localparam logic [3:0] ACT_SHOW_BYTE = 4'd4;
  localparam logic [3:0] ACT_SHOW_WORD = 4'd5;
  localparam logic [3:0] ACT_INIT      = 4'd6;
  localparam logic [3:0] ACT_CURS_ON   = 4'd7;
  localparam logic [3:0] ACT_CURS_OFF  = 4'd8;

  // delay classes
  localparam logic [1:0] WAIT_SHORT = 2'd0;
  localparam logic [1:0] WAIT_CLEAR = 2'd1;
  localparam logic [1:0] WAIT_POWER = 2'd2;

  localparam logic [7:0] LINE0_BASE   = 8'h80;
  localparam logic [7:0] LINE1_BASE   = 8'hc0;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_CURS_ON  = 8'h0f;
  localparam logic [7:0] CMD_CURS_OFF = 8'h0c;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_INIT,
    KIND_DIGITS
  } kind_t;

  typedef enum logic [1:0] {
    SEG_WAIT,
    SEG_BODY,
    SEG_CLR
  } seg_t;

  // one classified request, as held in the queue
  typedef struct packed {
    kind_t       kind;
    logic        rs;
    logic [7:0]  byte_val;
    logic [15:0] value;
    logic [2:0]  body_cnt;
    logic        pre_wait;
    logic        post_clear;
  } entry_t;

  // one bus step
  typedef struct packed {
    logic       strobe;
    logic       rs;
    logic [3:0] nib;
    logic [1:0] wait_class;
    logic       last;
  } step_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h2c;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h0c;
      default: c = 8'h0c;
    endcase
    return c;
  endfunction

  // floor(x / 10^k) = (x * recip) >> shift, exact over the range each place sees
  function automatic logic [16:0] dig_recip(input logic [2:0] k);
    logic [16:0] m;
    case (k)
      3'd0:    m = 17'd1;
      3'd1:    m = 17'd52429;
      3'd2:    m = 17'd656;
      3'd3:    m = 17'd16778;
      3'd4:    m = 17'd107375;
      default: m = 17'd1;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] dig_shift(input logic [2:0] k);
    logic [4:0] s;
    case (k)
      3'd0:    s = 5'd0;
      3'd1:    s = 5'd19;
      3'd2:    s = 5'd16;
      3'd3:    s = 5'd24;
      3'd4:    s = 5'd30;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

### rtl/lcdseq_front.sv
// Request classifier: turns one input word into a queue entry.
// Depends on lcdseq_pkg.
module lcdseq_front (
  input  logic [3:0]          action,
  input  logic [7:0]          data_byte,
  input  logic [5:0]          column,
  input  logic                row,
  input  logic [15:0]         number,
  output lcdseq_pkg::entry_t  ent,
  output logic                ent_valid
);
  import lcdseq_pkg::*;

  always_comb begin
    ent            = '0;
    ent.kind       = KIND_BYTE;
    ent.rs         = 1'b0;
    ent.byte_val   = data_byte;
    ent.value      = number;
    ent.body_cnt   = 3'd1;
    ent.pre_wait   = 1'b0;
    ent.post_clear = 1'b0;
    ent_valid      = 1'b1;
    case (action)
      ACT_CHAR: begin
        ent.rs = 1'b1;
      end
      ACT_COMMAND: begin
        ent.rs = 1'b0;
      end
      ACT_CLEAR: begin
        ent.body_cnt   = 3'd0;
        ent.post_clear = 1'b1;
      end
      ACT_CURSOR: begin
        ent.byte_val = (row ? LINE1_BASE : LINE0_BASE) + {2'b00, column};
      end
      ACT_SHOW_BYTE: begin
        ent.kind     = KIND_DIGITS;
        ent.rs       = 1'b1;
        ent.value    = {8'h00, number[7:0]};
        ent.body_cnt = 3'd3;
      end
      ACT_SHOW_WORD: begin
        ent.kind     = KIND_DIGITS;
        ent.rs       = 1'b1;
        ent.body_cnt = 3'd5;
      end
      ACT_INIT: begin
        ent.kind       = KIND_INIT;
        ent.body_cnt   = 3'd5;
        ent.pre_wait   = 1'b1;
        ent.post_clear = 1'b1;
      end
      ACT_CURS_ON: begin
        ent.byte_val = CMD_CURS_ON;
      end
      ACT_CURS_OFF: begin
        ent.byte_val = CMD_CURS_OFF;
      end
      default: begin
        ent_valid = 1'b0;  // unused codes are swallowed
      end
    endcase
  end

endmodule

### rtl/lcdseq_fifo.sv
// Short queue of classified requests between front and back.
// Depends on lcdseq_pkg.
module lcdseq_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  lcdseq_pkg::entry_t           push_ent,
  input  logic                         pop,
  output lcdseq_pkg::entry_t           head,
  output logic                         head_valid,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import lcdseq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign head       = mem[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == CW'(DEPTH));
  assign count      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_ent;
    end
  end

endmodule

### rtl/lcdseq_back.sv
// Step sequencer: walks a queued request and, unless the output is stalled,
// emits one bus step a cycle into the output register. Digits come from a
// reciprocal multiply per place. Depends on lcdseq_pkg.
module lcdseq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lcdseq_pkg::entry_t  head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdseq_pkg::step_t   out_step
);
  import lcdseq_pkg::*;

  entry_t      cur_r;
  logic        cur_valid_r, cur_valid_nxt;
  seg_t        seg_r, seg_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        lo_r, lo_nxt;
  logic [15:0] rem_r;
  logic [3:0]  q_r;
  logic        out_valid_r;
  step_t       out_step_r;

  step_t       step;
  logic        adv;
  logic        body_end;
  logic [7:0]  body_byte;
  logic [7:0]  clr_byte;
  logic [2:0]  place;
  logic [32:0] prod;
  logic [32:0] prod_sh;
  logic [17:0] sub_prod;
  seg_t        start_seg;

  assign adv       = cur_valid_r && (!out_valid_r || !out_stall);
  assign body_end  = (cnt_r == cur_r.body_cnt - 3'd1);
  assign place     = cur_r.body_cnt - 3'd1 - cnt_r;
  assign prod      = rem_r * dig_recip(place);
  assign prod_sh   = prod >> dig_shift(place);
  assign sub_prod  = q_r * pow10(place);
  assign start_seg = head.pre_wait ? SEG_WAIT :
                     ((head.body_cnt != 3'd0) ? SEG_BODY : SEG_CLR);

  // step produced by the current state
  always_comb begin
    case (cur_r.kind)
      KIND_INIT:   body_byte = init_cmd(cnt_r);
      KIND_DIGITS: body_byte = {ASCII_DIGIT_HI, q_r};
      default:     body_byte = cur_r.byte_val;
    endcase
    clr_byte = cnt_r[0] ? CMD_HOME : CMD_CLEAR;
    step     = '0;
    case (seg_r)
      SEG_WAIT: begin
        step.strobe     = 1'b0;
        step.rs         = 1'b0;
        step.nib        = 4'h0;
        step.wait_class = WAIT_POWER;
        step.last       = 1'b0;
      end
      SEG_BODY: begin
        step.strobe     = 1'b1;
        step.rs         = cur_r.rs;
        step.nib        = lo_r ? body_byte[3:0] : body_byte[7:4];
        step.wait_class = WAIT_SHORT;
        step.last       = lo_r && body_end && !cur_r.post_clear;
      end
      SEG_CLR: begin
        step.strobe     = 1'b1;
        step.rs         = 1'b0;
        step.nib        = lo_r ? clr_byte[3:0] : clr_byte[7:4];
        step.wait_class = lo_r ? WAIT_CLEAR : WAIT_SHORT;
        step.last       = lo_r && cnt_r[0];
      end
      default: begin
        step = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    seg_nxt       = seg_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    cur_valid_nxt = cur_valid_r;
    pop           = 1'b0;
    if (adv) begin
      case (seg_r)
        SEG_WAIT: begin
          seg_nxt = SEG_BODY;
          cnt_nxt = 3'd0;
          lo_nxt  = 1'b0;
        end
        SEG_BODY: begin
          if (!lo_r) begin
            lo_nxt = 1'b1;
          end else if (body_end) begin
            seg_nxt = SEG_CLR;
            cnt_nxt = 3'd0;
            lo_nxt  = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
            lo_nxt  = 1'b0;
          end
        end
        SEG_CLR: begin
          if (!lo_r) begin
            lo_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
            lo_nxt  = 1'b0;
          end
        end
        default: begin
          seg_nxt = SEG_WAIT;
        end
      endcase
      if (step.last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    // take the next request in the cycle the current one ends
    if ((!cur_valid_r || (adv && step.last)) && head_valid) begin
      pop           = 1'b1;
      cur_valid_nxt = 1'b1;
      seg_nxt       = start_seg;
      cnt_nxt       = 3'd0;
      lo_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      seg_r       <= SEG_WAIT;
      cnt_r       <= 3'd0;
      lo_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      seg_r       <= seg_nxt;
      cnt_r       <= cnt_nxt;
      lo_r        <= lo_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and digit datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (adv) begin
      out_step_r <= step;
    end
    if (pop) begin
      rem_r <= head.value;
    end else if (adv && seg_r == SEG_BODY && cur_r.kind == KIND_DIGITS && lo_r) begin
      rem_r <= rem_r - sub_prod[15:0];
    end
    if (adv && seg_r == SEG_BODY && !lo_r) begin
      q_r <= prod_sh[3:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_step  = out_step_r;

endmodule

### rtl/char_lcd_nibble_command_sequencer.sv
// Character LCD 4-bit bus sequencer, top level.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_fifo and lcdseq_back.
//
// Usage:
//   Input channel (in_*): one request word per handshake, accepted when
//   in_valid is high and in_stall low. Unused action codes are taken and
//   yield nothing.
//   Output channel (out_*): one bus step per word, taken when out_valid is
//   high and out_stall low; out_last marks the final step of a request.
//   When the queue is empty, a request passes the queue, the sequencer's
//   request register and the output register before its first step appears.
//   Throughput: one step per cycle while out_stall is low; a request has
//   2 steps for a byte, 4 for clear-and-home, 6/10 for 3/5 digits and
//   15 for init, as the step sequencer emits them; the next queued
//   request starts in the cycle after the previous one's last step.
//   Up to QDEPTH requests wait in the queue, so the front keeps accepting
//   while the back is busy or stalled, until the queue is full.
//   Reset clears the queue, the sequencer and out_valid.
//   While out_stall and out_valid are high the output word holds and the sequencer pauses.
module char_lcd_nibble_command_sequencer #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  input  logic [15:0] in_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_strobe_res,
  output logic        out_register_select,
  output logic [3:0]  out_nibble,
  output logic [1:0]  out_wait_class,
  output logic        out_last
);
  import lcdseq_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  entry_t         ent;
  logic           ent_valid;
  entry_t         head;
  logic           head_valid;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic [CW-1:0]  q_cnt;
  step_t          step;

  lcdseq_front u_front (
    .action    (in_action),
    .data_byte (in_data_byte),
    .column    (in_column),
    .row       (in_row),
    .number    (in_number),
    .ent       (ent),
    .ent_valid (ent_valid)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && ent_valid;

  lcdseq_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ent   (ent),
    .pop        (q_pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full),
    .count      (q_cnt)
  );

  lcdseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_step   (step)
  );

  assign out_strobe_res      = step.strobe;
  assign out_register_select = step.rs;
  assign out_nibble          = step.nib;
  assign out_wait_class      = step.wait_class;
  assign out_last            = step.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CW'(QDEPTH))
    else $error("request queue over depth");

  // a wait-only step is instruction-mode, power-up class and never ends a request
  a_wait_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_strobe_res |->
      !out_last && !out_register_select && out_wait_class == WAIT_POWER)
    else $error("malformed wait-only step");

  // power-up delay only on the wait-only step
  a_power_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strobe_res |->
      (out_wait_class == WAIT_SHORT || out_wait_class == WAIT_CLEAR))
    else $error("bad delay class on strobed step");

  // a wait-only step is always followed by the first init command nibble
  a_init_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_strobe_res |=>
      !out_valid || (out_strobe_res && !out_register_select && out_nibble == 4'h3))
    else $error("init sequence broken after wait step");

endmodule

### tb/tb_char_lcd_nibble_command_sequencer.sv
// Self-checking bench for the character LCD nibble sequencer: directed table, then random requests.
// Depends on lcdseq_pkg and char_lcd_nibble_command_sequencer; needs nothing else.
module tb_char_lcd_nibble_command_sequencer;
  import lcdseq_pkg::*;

  localparam logic [3:0] ACT_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] ACT_LAST_CODE    = 4'd15;
  localparam logic [7:0] DIGIT_ZERO       = 8'h30;
  localparam logic [39:0] POWERUP_CMDS    = 40'h33_32_2c_06_0c;
  localparam int RANDOM_REQUESTS = 250;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LIMIT_CYCLES    = 400000;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  data_byte;
    logic [5:0]  column;
    logic        row;
    logic [15:0] number;
  } lcd_req_t;

  typedef struct packed {
    logic       strobe;
    logic       rs;
    logic [3:0] nib;
    logic [1:0] wait_class;
    logic       last;
  } bus_step_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_action;
  logic [7:0]  in_data_byte;
  logic [5:0]  in_column;
  logic        in_row;
  logic [15:0] in_number;
  logic        out_valid;
  logic        out_stall;
  logic        out_strobe_res;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic [1:0]  out_wait_class;
  logic        out_last;

  bus_step_t pending_bus_steps[$];
  bus_step_t request_steps[$];
  lcd_req_t  table_reqs[$];
  int        table_typed_count[$];   // -1: use the predictor
  bus_step_t table_typed_steps[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        send_calm = 0;
  int        take_calm = 0;

  char_lcd_nibble_command_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_data_byte        (in_data_byte),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_number           (in_number),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_strobe_res      (out_strobe_res),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_class      (out_wait_class),
    .out_last            (out_last)
  );

  always #4 clk = ~clk;

  function automatic bus_step_t mk_step(input logic s, input logic rs, input logic [3:0] nib,
                                        input logic [1:0] wc, input logic last);
    return {s, rs, nib, wc, last};
  endfunction

  function automatic lcd_req_t mk_req(input logic [3:0] action, input logic [7:0] data_byte,
                                      input logic [5:0] column, input logic row,
                                      input logic [15:0] number);
    return {action, data_byte, column, row, number};
  endfunction

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR @%0d: %s", cycle_count, msg);
  endtask

  // --- predictor -----------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic rs, input logic [1:0] tail);
    request_steps.push_back(mk_step(1'b1, rs, b[7:4], WAIT_SHORT, 1'b0));
    request_steps.push_back(mk_step(1'b1, rs, b[3:0], tail, 1'b0));
  endtask

  task automatic push_clear_home();
    push_byte(CMD_CLEAR, 1'b0, WAIT_CLEAR);
    push_byte(CMD_HOME, 1'b0, WAIT_CLEAR);
  endtask

  // most significant digit first, leading zeros kept
  task automatic push_decimal(input int unsigned value, input int unsigned digits);
    int unsigned place;
    logic [7:0]  ch;
    place = (digits == 5) ? 10000 : 100;
    while (place > 0) begin
      ch = DIGIT_ZERO + 8'((value / place) % 10);
      push_byte(ch, 1'b1, WAIT_SHORT);
      place = place / 10;
    end
  endtask

  task automatic predict_bus_steps(input lcd_req_t r);
    logic [7:0] addr;
    bus_step_t  s;
    int         i;
    request_steps.delete();
    case (r.action)
      ACT_CHAR:      push_byte(r.data_byte, 1'b1, WAIT_SHORT);
      ACT_COMMAND:   push_byte(r.data_byte, 1'b0, WAIT_SHORT);
      ACT_CLEAR:     push_clear_home();
      ACT_CURSOR: begin
        addr = (r.row ? LINE1_BASE : LINE0_BASE) + {2'b00, r.column};
        push_byte(addr, 1'b0, WAIT_SHORT);
      end
      ACT_SHOW_BYTE: push_decimal(r.number[7:0], 3);
      ACT_SHOW_WORD: push_decimal(r.number, 5);
      ACT_INIT: begin
        request_steps.push_back(mk_step(1'b0, 1'b0, 4'h0, WAIT_POWER, 1'b0));
        for (i = 0; i < 5; i++) push_byte(POWERUP_CMDS[8*(4-i) +: 8], 1'b0, WAIT_SHORT);
        push_clear_home();
      end
      ACT_CURS_ON:   push_byte(CMD_CURS_ON, 1'b0, WAIT_SHORT);
      ACT_CURS_OFF:  push_byte(CMD_CURS_OFF, 1'b0, WAIT_SHORT);
      default: ;
    endcase
    for (i = 0; i < request_steps.size(); i++) begin
      s = request_steps[i];
      s.last = (i == request_steps.size() - 1);
      pending_bus_steps.push_back(s);
    end
  endtask

  // --- stimulus ------------------------------------------------------------

  task automatic add_row(input lcd_req_t r, input int n, input bus_step_t s0,
                         input bus_step_t s1);
    table_reqs.push_back(r);
    table_typed_count.push_back(n);
    if (n == 2) begin
      table_typed_steps.push_back(s0);
      table_typed_steps.push_back(s1);
    end
  endtask

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    r.action    = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE))
                                               : 4'($urandom_range(ACT_CHAR, ACT_CURS_OFF));
    r.data_byte = 8'($urandom);
    r.column    = 6'($urandom);
    r.row       = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       r.number = 16'd0;
      1:       r.number = 16'hffff;
      2:       r.number = 16'd9999 + 16'($urandom_range(0, 2));
      3:       r.number = 16'($urandom_range(0, 999));
      default: r.number = 16'($urandom);
    endcase
    return r;
  endfunction

  // word held until taken; in_valid left high so a back-to-back word needs no drop
  task automatic send_request(input lcd_req_t r);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = 0;
      send_calm = 20;
    end else begin
      gap = $urandom_range(0, 17);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= r.action;
    in_data_byte <= r.data_byte;
    in_column    <= r.column;
    in_row       <= r.row;
    in_number    <= r.number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bus_steps.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    lcd_req_t r;
    int       idx;
    int       k;
    int       n;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_CHAR;
    in_data_byte <= 8'h00;
    in_column    <= 6'd0;
    in_row       <= 1'b0;
    in_number    <= 16'h0000;

    add_row(mk_req(ACT_CHAR, 8'h00, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b1, 4'h0, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b1, 4'h0, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_CHAR, 8'hff, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b1, 4'hf, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b1, 4'hf, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_COMMAND, 8'h00, 6'd63, 1'b1, 16'hffff), 2,
            mk_step(1'b1, 1'b0, 4'h0, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'h0, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_COMMAND, 8'hff, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b0, 4'hf, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'hf, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_COMMAND, 8'ha5, 6'd0, 1'b0, 16'h0000), -1, '0, '0);
    add_row(mk_req(ACT_CLEAR, 8'hff, 6'd63, 1'b1, 16'hffff), -1, '0, '0);
    add_row(mk_req(ACT_CURSOR, 8'h00, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b0, 4'h8, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'h0, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_CURSOR, 8'h00, 6'd63, 1'b1, 16'h0000), 2,
            mk_step(1'b1, 1'b0, 4'hf, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'hf, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_CURSOR, 8'h00, 6'd39, 1'b0, 16'h0000), -1, '0, '0);
    add_row(mk_req(ACT_CURSOR, 8'hff, 6'd21, 1'b1, 16'hffff), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_BYTE, 8'h00, 6'd0, 1'b0, 16'h0000), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_BYTE, 8'h00, 6'd0, 1'b0, 16'hffff), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_BYTE, 8'h00, 6'd0, 1'b0, 16'h0109), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_WORD, 8'h00, 6'd0, 1'b0, 16'h0000), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_WORD, 8'h00, 6'd0, 1'b0, 16'hffff), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_WORD, 8'h00, 6'd0, 1'b0, 16'd10000), -1, '0, '0);
    add_row(mk_req(ACT_SHOW_WORD, 8'h00, 6'd0, 1'b0, 16'd9), -1, '0, '0);
    add_row(mk_req(ACT_INIT, 8'h00, 6'd0, 1'b0, 16'h0000), -1, '0, '0);
    add_row(mk_req(ACT_CURS_ON, 8'h00, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b0, 4'h0, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'hf, WAIT_SHORT, 1'b1));
    add_row(mk_req(ACT_CURS_OFF, 8'h00, 6'd0, 1'b0, 16'h0000), 2,
            mk_step(1'b1, 1'b0, 4'h0, WAIT_SHORT, 1'b0), mk_step(1'b1, 1'b0, 4'hc, WAIT_SHORT, 1'b1));
    // unused codes are taken and give nothing
    add_row(mk_req(ACT_FIRST_UNUSED, 8'hff, 6'd63, 1'b1, 16'hffff), 0, '0, '0);
    add_row(mk_req(ACT_LAST_CODE, 8'h00, 6'd0, 1'b0, 16'h0000), 0, '0, '0);
    add_row(mk_req(ACT_CHAR, 8'h5a, 6'd63, 1'b1, 16'hffff), -1, '0, '0);
    add_row(mk_req(ACT_INIT, 8'hff, 6'd63, 1'b1, 16'hffff), -1, '0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    k = 0;
    for (idx = 0; idx < table_reqs.size(); idx++) begin
      send_request(table_reqs[idx]);
      if (table_typed_count[idx] < 0) begin
        predict_bus_steps(table_reqs[idx]);
      end else begin
        for (n = 0; n < table_typed_count[idx]; n++) begin
          pending_bus_steps.push_back(table_typed_steps[k]);
          k++;
        end
      end
    end
    hold_until_drained();

    for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
      if (idx == RANDOM_REQUESTS / 2) hold_until_drained();
      r = random_request();
      send_request(r);
      predict_bus_steps(r);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_bus_steps.size() != 0)
      report_error($sformatf("%0d expected words never arrived", pending_bus_steps.size()));
    if (errors == 0) begin
      $display("char_lcd_nibble_command_sequencer test passed");
    end else begin
      $display("char_lcd_nibble_command_sequencer test failed");
    end
    $finish;
  end

  // --- result side ---------------------------------------------------------

  initial begin : sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (take_calm > 0) begin
        hold = 0;
        take_calm--;
      end else if ($urandom_range(0, 9) == 0) begin
        hold = 0;
        take_calm = 30;
      end else begin
        hold = $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    bus_step_t got;
    bus_step_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_strobe_res, out_register_select, out_nibble, out_wait_class, out_last};
      if (pending_bus_steps.size() == 0) begin
        report_error($sformatf("unexpected word %h", got));
      end else begin
        want = pending_bus_steps.pop_front();
        if (got.strobe !== want.strobe)
          report_error($sformatf("strobe_res %b, want %b", got.strobe, want.strobe));
        if (got.rs !== want.rs)
          report_error($sformatf("register_select %b, want %b", got.rs, want.rs));
        if (got.nib !== want.nib)
          report_error($sformatf("nibble %h, want %h", got.nib, want.nib));
        if (got.wait_class !== want.wait_class)
          report_error($sformatf("wait_class %0d, want %0d", got.wait_class, want.wait_class));
        if (got.last !== want.last)
          report_error($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("char_lcd_nibble_command_sequencer test failed");
      $finish;
    end
  end

endmodule
